@@ rtl/core/hmct_pkg.sv @@
package hmct_pkg;

  localparam int unsigned TICK_W       = 16;
  localparam int unsigned SECOND_W     = 8;
  localparam int unsigned HALF_W       = 5;
  localparam int unsigned PHASE_W      = 4;
  localparam int unsigned SEG_W        = 8;
  localparam int unsigned CFG_INDEX_W  = 1;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [TICK_W-1:0]   TICKS_PER_SECOND_RESET = 16'd1000;
  localparam logic [SECOND_W-1:0] SECONDS_PER_STEP_RESET = 8'd30;

  localparam logic [HALF_W-1:0]  HALF_MINUTE_MOD   = 5'd20;
  localparam logic [HALF_W-1:0]  ALARM_INDEX       = 5'd20;
  localparam logic [HALF_W-1:0]  DEFAULT_SET_VALUE = 5'd6;
  localparam logic [PHASE_W-1:0] PHASE_LAST        = 4'd8;
  localparam logic [PHASE_W-1:0] PHASE_LIGHT       = 4'd0;
  localparam logic [PHASE_W-1:0] PHASE_SAMPLE      = 4'd3;
  localparam logic [PHASE_W-1:0] PHASE_BUZZ        = 4'd4;
  localparam logic [TICK_W-1:0]  ALARM_DARK_TICK   = 16'h0200;
  localparam logic [TICK_W-1:0]  BLINK_MASK        = 16'h0080;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TICKS_PER_SECOND = 1'd0,
    REG_SECONDS_PER_STEP = 1'd1
  } cfg_reg_t;

  typedef struct packed {
    logic held;
    logic sleep;
    logic alarm;
    logic entry;
  } flags_t;

  localparam flags_t FLAGS_SLEEP_ONLY = '{held: 1'b0, sleep: 1'b1, alarm: 1'b0, entry: 1'b0};
  localparam flags_t FLAGS_ENTRY_ONLY = '{held: 1'b0, sleep: 1'b0, alarm: 1'b0, entry: 1'b1};

  typedef struct packed {
    logic [TICK_W-1:0]   tick_count;
    logic [SECOND_W-1:0] second_count;
    logic [HALF_W-1:0]   half_minute_count;
    logic [HALF_W-1:0]   last_set_value;
    logic [PHASE_W-1:0]  display_phase;
    flags_t              flags;
    logic                light_latch;
    logic                buzzer_latch;
    logic                previous_button;
  } timer_state_t;

  localparam timer_state_t STATE_RESET = '{
    tick_count:        '0,
    second_count:      '0,
    half_minute_count: '0,
    last_set_value:    DEFAULT_SET_VALUE,
    display_phase:     '0,
    flags:             FLAGS_SLEEP_ONLY,
    light_latch:       1'b0,
    buzzer_latch:      1'b0,
    previous_button:   1'b0
  };

  typedef struct packed {
    logic [SEG_W-1:0]  segments;
    logic [HALF_W-1:0] digit_index;
    logic              light_on;
    logic              buzzer_on;
    logic              asleep;
  } result_t;

  function automatic logic [SEG_W-1:0] glyph(input logic [HALF_W-1:0] idx);
    logic [SEG_W-1:0] pattern;
    case (idx)
      5'd0:    pattern = 8'hDE;
      5'd1:    pattern = 8'hFE;
      5'd2:    pattern = 8'h50;
      5'd3:    pattern = 8'h70;
      5'd4:    pattern = 8'hC7;
      5'd5:    pattern = 8'hE7;
      5'd6:    pattern = 8'hD5;
      5'd7:    pattern = 8'hF5;
      5'd8:    pattern = 8'h59;
      5'd9:    pattern = 8'h79;
      5'd10:   pattern = 8'h9D;
      5'd11:   pattern = 8'hBD;
      5'd12:   pattern = 8'h9F;
      5'd13:   pattern = 8'hBF;
      5'd14:   pattern = 8'hD0;
      5'd15:   pattern = 8'hF0;
      5'd16:   pattern = 8'hDF;
      5'd17:   pattern = 8'hFF;
      5'd18:   pattern = 8'hDD;
      5'd19:   pattern = 8'hFD;
      5'd20:   pattern = 8'h85;
      default: pattern = '0;
    endcase
    return pattern;
  endfunction

endpackage

@@ rtl/core/hmct_tick_if.sv @@
interface hmct_tick_if;
  logic valid;
  logic ready;
  logic button_level;

  modport source (output valid, output button_level, input ready);
  modport sink (input valid, input button_level, output ready);
endinterface

@@ rtl/core/hmct_result_if.sv @@
interface hmct_result_if;
  logic                         valid;
  logic                         ready;
  logic [hmct_pkg::SEG_W-1:0]  segments;
  logic [hmct_pkg::HALF_W-1:0] digit_index;
  logic                         light_on;
  logic                         buzzer_on;
  logic                         asleep;

  modport source (output valid, output segments, output digit_index, output light_on,
                  output buzzer_on, output asleep, input ready);
  modport sink (input valid, input segments, input digit_index, input light_on,
                input buzzer_on, input asleep, output ready);
endinterface

@@ rtl/core/hmct_cfg_if.sv @@
interface hmct_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [hmct_pkg::CFG_INDEX_W-1:0] index;
  logic [hmct_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/half_minute_countdown_timer.sv @@
// Half-minute countdown timer. Each tick beat on the tick channel carries the sampled
// button level and produces exactly one result beat (segment pattern, digit index, light,
// buzzer, sleep flag) taken from the state after that tick. One tick is taken every clock
// while tick ready is high; the state update is a single registered step and the result
// is registered in the output buffer. A two-entry buffer lets ticks keep flowing while one
// result waits; tick ready drops only when both entries are full. Configuration writes
// (index 0 ticks_per_second, index 1 seconds_per_step) are always accepted and should be
// issued only while no tick is in flight.
module half_minute_countdown_timer (
  input  logic           clk,
  input  logic           rst,
  hmct_tick_if.sink      tick,
  hmct_result_if.source  result,
  hmct_cfg_if.sink       cfg
);

  hmct_pkg::timer_state_t           state;
  hmct_pkg::timer_state_t           state_next;
  hmct_pkg::result_t                res_new;
  hmct_pkg::result_t                head;
  hmct_pkg::result_t                skid;
  logic                             head_valid;
  logic                             skid_valid;
  logic [hmct_pkg::TICK_W-1:0]     ticks_per_second;
  logic [hmct_pkg::SECOND_W-1:0]   seconds_per_step;
  logic                             push;
  logic                             pop;

  hmct_step u_step (
    .cur              (state),
    .level            (tick.button_level),
    .ticks_per_second (ticks_per_second),
    .seconds_per_step (seconds_per_step),
    .nxt              (state_next),
    .res              (res_new)
  );

  assign cfg.ready  = 1'b1;
  assign tick.ready = !skid_valid;
  assign push       = tick.valid && tick.ready;
  assign pop        = head_valid && result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= hmct_pkg::TICKS_PER_SECOND_RESET;
      seconds_per_step <= hmct_pkg::SECONDS_PER_STEP_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        hmct_pkg::REG_TICKS_PER_SECOND: ticks_per_second <= cfg.data;
        hmct_pkg::REG_SECONDS_PER_STEP: seconds_per_step <= cfg.data[hmct_pkg::SECOND_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= hmct_pkg::STATE_RESET;
    end else if (push) begin
      state <= state_next;
    end
  end

  // two-entry output buffer: head drives the port, skid catches a beat while head stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        head_valid <= push;
      end
    end else if (push) begin
      if (head_valid) begin
        skid_valid <= 1'b1;
      end else begin
        head_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      head <= skid_valid ? skid : res_new;
    end else if (push) begin
      if (head_valid) begin
        skid <= res_new;
      end else begin
        head <= res_new;
      end
    end
  end

  assign result.valid       = head_valid;
  assign result.segments    = head.segments;
  assign result.digit_index = head.digit_index;
  assign result.light_on    = head.light_on;
  assign result.buzzer_on   = head.buzzer_on;
  assign result.asleep      = head.asleep;

`ifndef NO_ASSERTIONS
  a_skid_needs_head: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> head_valid)
    else $error("skid entry held without a head entry");

  a_sleep_flags_alone: assert property (@(posedge clk) disable iff (rst)
    state.flags.sleep |-> (!state.flags.held && !state.flags.alarm && !state.flags.entry))
    else $error("sleep flag set together with another mode flag");

  a_half_count_range: assert property (@(posedge clk) disable iff (rst)
    state.half_minute_count < hmct_pkg::HALF_MINUTE_MOD)
    else $error("half-minute count out of range");

  a_asleep_dark: assert property (@(posedge clk) disable iff (rst)
    (head_valid && head.asleep) |-> (!head.light_on && !head.buzzer_on))
    else $error("light or buzzer reported while asleep");
`endif

endmodule

@@ rtl/core/hmct_step.sv @@
module hmct_step (
  input  hmct_pkg::timer_state_t             cur,
  input  logic                               level,
  input  logic [hmct_pkg::TICK_W-1:0]        ticks_per_second,
  input  logic [hmct_pkg::SECOND_W-1:0]      seconds_per_step,
  output hmct_pkg::timer_state_t             nxt,
  output hmct_pkg::result_t                  res
);

  logic [hmct_pkg::TICK_W-1:0]   tick_inc;
  logic [hmct_pkg::SECOND_W-1:0] sec_val;
  logic [hmct_pkg::HALF_W-1:0]   half_inc;
  logic [hmct_pkg::HALF_W-1:0]   half_dec;
  logic [hmct_pkg::HALF_W-1:0]   idx;
  logic                          dark;

  assign tick_inc = cur.tick_count + 16'd1;
  assign half_inc = (cur.half_minute_count >= hmct_pkg::HALF_MINUTE_MOD - 5'd1) ? '0
                    : cur.half_minute_count + 5'd1;
  assign half_dec = (cur.half_minute_count != '0) ? cur.half_minute_count - 5'd1 : '0;
  assign dark = (cur.flags.alarm && cur.tick_count >= hmct_pkg::ALARM_DARK_TICK) ||
                (cur.second_count == '0 && !cur.flags.entry &&
                 (cur.tick_count & hmct_pkg::BLINK_MASK) != '0);

  always_comb begin
    nxt     = cur;
    sec_val = cur.second_count;
    if (cur.flags.sleep) begin
      // only a release wakes the timer
      if (cur.previous_button && !level) begin
        nxt.tick_count        = '0;
        nxt.second_count      = '0;
        nxt.flags             = hmct_pkg::FLAGS_ENTRY_ONLY;
        nxt.half_minute_count = (cur.last_set_value != '0) ? cur.last_set_value
                                : hmct_pkg::DEFAULT_SET_VALUE;
      end
    end else if (cur.flags.held) begin
      if (!level) begin
        nxt.flags.held = 1'b0;
        if (cur.flags.alarm) begin
          nxt.flags        = hmct_pkg::FLAGS_SLEEP_ONLY;
          nxt.light_latch  = 1'b0;
          nxt.buzzer_latch = 1'b0;
        end else begin
          nxt.half_minute_count = half_inc;
          if (half_inc != '0) begin
            nxt.last_set_value = half_inc;
          end
          nxt.tick_count   = '0;
          nxt.second_count = '0;
          nxt.flags.entry  = 1'b1;
        end
      end
    end else begin
      // display phase
      nxt.display_phase = (cur.display_phase >= hmct_pkg::PHASE_LAST) ? '0
                          : cur.display_phase + 4'd1;
      case (cur.display_phase)
        hmct_pkg::PHASE_LIGHT: begin
          nxt.light_latch = !dark;
          if (!dark) begin
            nxt.buzzer_latch = 1'b0;
          end
        end
        hmct_pkg::PHASE_SAMPLE: begin
          nxt.light_latch  = 1'b0;
          nxt.buzzer_latch = 1'b0;
          if (level) begin
            nxt.flags.held = 1'b1;
          end
        end
        hmct_pkg::PHASE_BUZZ: begin
          nxt.buzzer_latch = cur.flags.alarm && cur.tick_count < hmct_pkg::ALARM_DARK_TICK &&
                             (cur.tick_count & hmct_pkg::BLINK_MASK) != '0;
        end
        default: begin
        end
      endcase
      // tick and second counting
      if (tick_inc < ticks_per_second) begin
        nxt.tick_count = tick_inc;
      end else begin
        nxt.tick_count = '0;
        if (cur.flags.entry && cur.half_minute_count == '0) begin
          nxt.flags        = hmct_pkg::FLAGS_SLEEP_ONLY;
          nxt.light_latch  = 1'b0;
          nxt.buzzer_latch = 1'b0;
          nxt.second_count = '0;
        end else begin
          if (cur.flags.entry) begin
            nxt.flags.entry = 1'b0;
            sec_val         = '0;
          end else begin
            sec_val = cur.second_count + 8'd1;
          end
          if (sec_val >= seconds_per_step) begin
            nxt.second_count      = '0;
            nxt.half_minute_count = half_dec;
            if (half_dec == '0) begin
              nxt.flags.alarm = 1'b1;
            end
            nxt.flags.entry = 1'b0;
          end else begin
            nxt.second_count = sec_val;
          end
        end
      end
    end
    nxt.previous_button = level;
  end

  assign idx             = nxt.flags.alarm ? hmct_pkg::ALARM_INDEX : nxt.half_minute_count;
  assign res.segments    = hmct_pkg::glyph(idx);
  assign res.digit_index = idx;
  assign res.light_on    = !nxt.flags.sleep && nxt.light_latch;
  assign res.buzzer_on   = !nxt.flags.sleep && nxt.buzzer_latch;
  assign res.asleep      = nxt.flags.sleep;

endmodule
